// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// base form: clocked property, disabled while reset is low
`define ASSERT_CLKRST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    `ASSERT_CLKRST(lbl, clk, rst_n, (pre) |-> (post), msg)

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    `ASSERT_CLKRST(lbl, clk, rst_n, (pre) |=> (post), msg)

`endif

// ----- hw/rtl/rar_pkg.sv -----
// ----------------------------------------------------------------------------
// rar_pkg
// shared widths, operation codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rar_pkg;

    // operand width of the four fraction fields
    localparam int OPERAND_WIDTH = 16;

    // operation codes
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    // internal widths: one product, and the numerator sum (one bit wider, at most 64)
    localparam int PROD_W = 2 * OPERAND_WIDTH;
    localparam int CALC_W = (2 * OPERAND_WIDTH + 1 > 64) ? 64 : 2 * OPERAND_WIDTH + 1;
    localparam int CNT_W  = $clog2(CALC_W);

    // result field widths
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 32;

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RES_NUM_W + RES_DEN_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - RES_NUM_W - RES_DEN_W;

    // product slots of the shared multiplier
    localparam logic [1:0] SLOT_NUM_A = 2'd0;
    localparam logic [1:0] SLOT_NUM_B = 2'd1;
    localparam logic [1:0] SLOT_DEN   = 2'd2;

    typedef logic signed [OPERAND_WIDTH-1:0] t_operand;

    // commands from the controller
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_slot;
        logic       sum_en;
        logic       gcd_init;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } t_dp_cmd;

    // status back to the controller
    typedef struct packed {
        logic err;
        logic num_zero;
        logic gcd_done;
    } t_dp_status;

endpackage

// ----- hw/rtl/rational_arithmetic_reduce.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_reduce
// adds, subtracts, multiplies or divides two fractions and reduces the result
// ----------------------------------------------------------------------------
// One request at a time. After a request is taken the block runs its
// single shared multiplier (two cross products and the denominator
// product), then the sum and the zero checks, then the binary gcd loop
// (one subtract-or-shift per cycle) and the restoring divider that takes
// the gcd out of both magnitudes, one quotient bit per cycle. An error or
// a zero numerator skips the gcd and divide. The result sits in an output
// register, so the next request is taken while it waits. An error (zero
// input denominator or division by a zero numerator) returns zero fields
// with tuser set; a zero numerator comes back unreduced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rational_arithmetic_reduce (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: a_num, a_den, b_num, b_den (lowest bits first)
    input  logic [rar_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: operation
    input  logic [rar_pkg::OP_W-1:0]          s_axis_tuser,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: res_num, res_den, zero padding (lowest bits first)
    output logic [rar_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: status
    output logic                              m_axis_tuser
);

    localparam int OW = rar_pkg::OPERAND_WIDTH;

    rar_pkg::t_dp_cmd                     w_cmd;
    rar_pkg::t_dp_status                  w_status;
    logic signed [rar_pkg::RES_NUM_W-1:0] w_res_num;
    logic signed [rar_pkg::RES_DEN_W-1:0] w_res_den;
    logic                                 w_res_err;

    // sequencer
    rar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic
    rar_datapath u_datapath (
        .i_clk        (i_clk),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_operation  (s_axis_tuser),
        .i_a_num      (s_axis_tdata[OW-1:0]),
        .i_a_den      (s_axis_tdata[2*OW-1:OW]),
        .i_b_num      (s_axis_tdata[3*OW-1:2*OW]),
        .i_b_den      (s_axis_tdata[4*OW-1:3*OW]),
        .o_res_num    (w_res_num),
        .o_res_den    (w_res_den),
        .o_status_err (w_res_err)
    );

    // result packing
    assign m_axis_tdata = {{rar_pkg::OUT_PAD_W{1'b0}}, w_res_den, w_res_num};
    assign m_axis_tuser = w_res_err;

    // a taken request keeps the input side closed for the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready, "input still open after accept")
    // error results carry zero fields
    `ASSERT_IMPLIES(a_err_zero_fields, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "error result with nonzero fields")
    // a fresh result means the sequencer has gone back to idle
    `ASSERT_IMPLIES(a_idle_on_result, i_clk, i_rst_n,
        $rose(m_axis_tvalid), s_axis_tready, "result loaded without returning to idle")

endmodule

// ----- hw/rtl/rar_ctrl.sv -----
// ----------------------------------------------------------------------------
// rar_ctrl
// sequencer: multiply slots, sum, checks, gcd loop, divide loop, result hand-off
// ----------------------------------------------------------------------------
module rar_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  rar_pkg::t_dp_status  i_status,
    output rar_pkg::t_dp_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam logic [rar_pkg::CNT_W-1:0] DIV_LAST = rar_pkg::CNT_W'(rar_pkg::CALC_W - 1);

    logic [3:0]                r_state, n_state;
    logic [rar_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_out_valid, n_out_valid;
    logic                      w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = rar_pkg::SLOT_NUM_A;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = rar_pkg::SLOT_NUM_B;
                n_state        = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_slot = rar_pkg::SLOT_DEN;
                n_state        = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.err || i_status.num_zero) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.gcd_init = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt          = DIV_LAST;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hw/rtl/rar_datapath.sv -----
// ----------------------------------------------------------------------------
// rar_datapath
// shared multiplier, numerator sum, binary gcd and two-lane restoring divider
// ----------------------------------------------------------------------------
module rar_datapath (
    input  logic                                i_clk,
    input  rar_pkg::t_dp_cmd                    i_cmd,
    output rar_pkg::t_dp_status                 o_status,
    input  logic [rar_pkg::OP_W-1:0]            i_operation,
    input  rar_pkg::t_operand                   i_a_num,
    input  rar_pkg::t_operand                   i_a_den,
    input  rar_pkg::t_operand                   i_b_num,
    input  rar_pkg::t_operand                   i_b_den,
    output logic signed [rar_pkg::RES_NUM_W-1:0] o_res_num,
    output logic signed [rar_pkg::RES_DEN_W-1:0] o_res_den,
    output logic                                o_status_err
);

    localparam int W = rar_pkg::CALC_W;

    // magnitude of a signed working value
    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        logic [W-1:0] ux;
        ux = x;
        return x[W-1] ? (~ux + 1'b1) : ux;
    endfunction

    logic [rar_pkg::OP_W-1:0]          r_op;
    rar_pkg::t_operand                 r_an, r_ad, r_bn, r_bd;
    logic signed [rar_pkg::PROD_W-1:0] r_prod_a, r_prod_b;
    logic signed [W-1:0]               r_num, r_den;
    logic [W-1:0]                      r_u, r_v, r_mn, r_md, r_rem_n, r_rem_d;
    logic signed [rar_pkg::RES_NUM_W-1:0] r_res_num;
    logic signed [rar_pkg::RES_DEN_W-1:0] r_res_den;
    logic                              r_res_err;

    rar_pkg::t_operand                 w_mul_x, w_mul_y;
    logic signed [rar_pkg::PROD_W-1:0] w_product;
    logic signed [W-1:0]               w_ext_a, w_ext_b, w_sum;
    logic [W:0]                        w_trial_n, w_trial_d, w_divisor;
    logic                              w_ge_n, w_ge_d;
    logic [W-1:0]                      w_q_num, w_q_den;
    logic signed [W-1:0]               w_sq_num, w_sq_den;

    // operand selection for the shared multiplier
    always_comb begin
        case (i_cmd.mul_slot)
            rar_pkg::SLOT_NUM_A: begin
                w_mul_x = r_an;
                w_mul_y = (r_op == rar_pkg::OP_MUL) ? r_bn : r_bd;
            end
            rar_pkg::SLOT_NUM_B: begin
                w_mul_x = r_bn;
                w_mul_y = r_ad;
            end
            default: begin
                w_mul_x = r_ad;
                w_mul_y = (r_op == rar_pkg::OP_DIV) ? r_bn : r_bd;
            end
        endcase
    end

    assign w_product = w_mul_x * w_mul_y;

    // numerator from the two cross products
    assign w_ext_a = W'(r_prod_a);
    assign w_ext_b = W'(r_prod_b);

    always_comb begin
        case (r_op)
            rar_pkg::OP_ADD: w_sum = w_ext_a + w_ext_b;
            rar_pkg::OP_SUB: w_sum = w_ext_a - w_ext_b;
            default:         w_sum = w_ext_a;
        endcase
    end

    // status to the controller
    assign o_status.err = (r_ad == '0) || (r_bd == '0) || (r_den == '0)
                       || ((r_op == rar_pkg::OP_DIV) && (r_bn == '0));
    assign o_status.num_zero = (r_num == '0);
    assign o_status.gcd_done = (r_u == r_v);

    // restoring divide step, one quotient bit per lane
    assign w_divisor = {1'b0, r_u};
    assign w_trial_n = {r_rem_n, r_mn[W-1]};
    assign w_trial_d = {r_rem_d, r_md[W-1]};
    assign w_ge_n    = (w_trial_n >= w_divisor);
    assign w_ge_d    = (w_trial_d >= w_divisor);

    // signed quotients once the divide has finished
    assign w_q_num  = r_num[W-1] ? (~r_mn + 1'b1) : r_mn;
    assign w_q_den  = r_den[W-1] ? (~r_md + 1'b1) : r_md;
    assign w_sq_num = w_q_num;
    assign w_sq_den = w_q_den;

    // operand capture, products and sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_an <= i_a_num;
            r_ad <= i_a_den;
            r_bn <= i_b_num;
            r_bd <= i_b_den;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_slot)
                rar_pkg::SLOT_NUM_A: r_prod_a <= w_product;
                rar_pkg::SLOT_NUM_B: r_prod_b <= w_product;
                default:             r_den    <= W'(w_product);
            endcase
        end
        if (i_cmd.sum_en) begin
            r_num <= w_sum;
        end
    end

    // binary gcd; common factors of two also come off the dividends
    always_ff @(posedge i_clk) begin
        if (i_cmd.gcd_init) begin
            r_u  <= mag(r_num);
            r_v  <= mag(r_den);
            r_mn <= mag(r_num);
            r_md <= mag(r_den);
        end else if (i_cmd.gcd_step) begin
            if (!r_u[0] && !r_v[0]) begin
                r_u  <= r_u >> 1;
                r_v  <= r_v >> 1;
                r_mn <= r_mn >> 1;
                r_md <= r_md >> 1;
            end else if (!r_u[0]) begin
                r_u <= r_u >> 1;
            end else if (!r_v[0]) begin
                r_v <= r_v >> 1;
            end else if (r_u > r_v) begin
                r_u <= (r_u - r_v) >> 1;
            end else begin
                r_v <= (r_v - r_u) >> 1;
            end
        end else if (i_cmd.div_step) begin
            r_mn <= {r_mn[W-2:0], w_ge_n};
            r_md <= {r_md[W-2:0], w_ge_d};
        end
    end

    // divider remainders
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem_n <= '0;
            r_rem_d <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_n <= w_ge_n ? W'(w_trial_n - w_divisor) : w_trial_n[W-1:0];
            r_rem_d <= w_ge_d ? W'(w_trial_d - w_divisor) : w_trial_d[W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (o_status.err) begin
                r_res_num <= '0;
                r_res_den <= '0;
                r_res_err <= 1'b1;
            end else if (o_status.num_zero) begin
                r_res_num <= rar_pkg::RES_NUM_W'(r_num);
                r_res_den <= rar_pkg::RES_DEN_W'(r_den);
                r_res_err <= 1'b0;
            end else begin
                r_res_num <= rar_pkg::RES_NUM_W'(w_sq_num);
                r_res_den <= rar_pkg::RES_DEN_W'(w_sq_den);
                r_res_err <= 1'b0;
            end
        end
    end

    assign o_res_num    = r_res_num;
    assign o_res_den    = r_res_den;
    assign o_status_err = r_res_err;

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the fraction add/sub/mul/div unit with gcd reduction
// ----------------------------------------------------------------------------
// A directed table covers the extreme operands, every operation, sign
// handling, zero numerators and the error cases. Random requests follow.
// Each accepted request gets its expected reduced fraction from its row or
// a local integer predictor. Each returned result is compared field by
// field with the oldest expectation. Both sides idle at random. The sink is
// held off for a long stretch so the unit backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int    CLK_HALF_NS       = 4;
    localparam int    RESET_CYCLES      = 3;
    localparam int    RANDOM_BLOCKS     = 19;
    localparam int    BLOCK_REQUESTS    = 100;
    localparam int    BACKLOG_REQUESTS  = 12;
    localparam int    SINK_HOLD_CYCLES  = 400;
    localparam int    DRAIN_CYCLES      = 150;
    localparam int    MAX_REPORTS       = 10;
    localparam longint TIMEOUT_NS       = 64'd20_000_000;

    // one request: operation and the two fractions
    typedef struct packed {
        logic [rar_pkg::OP_W-1:0] op;
        rar_pkg::t_operand        a_num;
        rar_pkg::t_operand        a_den;
        rar_pkg::t_operand        b_num;
        rar_pkg::t_operand        b_den;
    } t_request;

    // one result: reduced fraction and error flag
    typedef struct packed {
        logic signed [rar_pkg::RES_NUM_W-1:0] num;
        logic signed [rar_pkg::RES_DEN_W-1:0] den;
        logic                                 err;
    } t_fraction;

    // directed row: request, and its result where known by inspection
    typedef struct packed {
        t_request  req;
        logic      known;
        t_fraction want;
    } t_row;

    localparam int N_ROWS = 23;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        '{'{rar_pkg::OP_ADD, 1, 2, 1, 3},                     1'b1, '{5, 6, 1'b0}},
        // zero numerator stays unreduced
        '{'{rar_pkg::OP_SUB, 1, 2, 1, 2},                     1'b1, '{0, 4, 1'b0}},
        '{'{rar_pkg::OP_MUL, 2, 4, 3, 6},                     1'b1, '{1, 4, 1'b0}},
        '{'{rar_pkg::OP_DIV, 1, 2, 1, 4},                     1'b1, '{2, 1, 1'b0}},
        // zero input denominators
        '{'{rar_pkg::OP_ADD, 3, 0, 5, 7},                     1'b1, '{0, 0, 1'b1}},
        '{'{rar_pkg::OP_MUL, 3, 7, 5, 0},                     1'b1, '{0, 0, 1'b1}},
        // division by a zero fraction
        '{'{rar_pkg::OP_DIV, 3, 7, 0, 9},                     1'b1, '{0, 0, 1'b1}},
        '{'{rar_pkg::OP_SUB, 1, 0, 1, 0},                     1'b1, '{0, 0, 1'b1}},
        '{'{rar_pkg::OP_DIV, 5, 0, 0, 3},                     1'b1, '{0, 0, 1'b1}},
        // most negative operands everywhere
        '{'{rar_pkg::OP_ADD, -32768, -32768, -32768, -32768}, 1'b1, '{2, 1, 1'b0}},
        '{'{rar_pkg::OP_MUL, 32767, -32768, 32767, -32768},   1'b0, '{0, 0, 1'b0}},
        '{'{rar_pkg::OP_SUB, -32768, 1, 32767, 1},            1'b1, '{-65535, 1, 1'b0}},
        // negative denominator is kept as computed
        '{'{rar_pkg::OP_MUL, 1, -1, 1, 1},                    1'b1, '{1, -1, 1'b0}},
        '{'{rar_pkg::OP_DIV, -32768, 32767, -32768, 32767},   1'b1, '{-1, -1, 1'b0}},
        '{'{rar_pkg::OP_ADD, 32767, 32767, 32767, 32767},     1'b1, '{2, 1, 1'b0}},
        '{'{rar_pkg::OP_SUB, -32768, -32768, 32767, 32767},   1'b0, '{0, 0, 1'b0}},
        '{'{rar_pkg::OP_MUL, 0, 5, 3, 7},                     1'b1, '{0, 35, 1'b0}},
        '{'{rar_pkg::OP_DIV, 7, 1, -7, 1},                    1'b1, '{1, -1, 1'b0}},
        '{'{rar_pkg::OP_ADD, 12345, -6789, -4321, 1000},      1'b0, '{0, 0, 1'b0}},
        '{'{rar_pkg::OP_DIV, 32767, -1, -32768, -1},          1'b0, '{0, 0, 1'b0}},
        '{'{rar_pkg::OP_MUL, -1, -1, -1, -1},                 1'b1, '{1, 1, 1'b0}},
        '{'{rar_pkg::OP_ADD, 0, -1, 0, -32768},               1'b1, '{0, 32768, 1'b0}},
        '{'{rar_pkg::OP_DIV, -32768, 1, 1, -32768},           1'b0, '{0, 0, 1'b0}}
    };

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [rar_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [rar_pkg::OP_W-1:0]       s_axis_tuser  = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [rar_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tuser;

    t_fraction pending_fractions [$];
    int        mismatch_count = 0;
    bit        sink_hold_request = 1'b0;
    bit        sink_holding      = 1'b0;
    t_fraction got_fraction;
    t_fraction want_fraction;

    rational_arithmetic_reduce i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // combine the fractions in 64-bit integers, then reduce by the gcd
    function automatic t_fraction reduce_fraction(t_request req);
        longint    an, ad, bn, bd;
        longint    num, den;
        longint    x, y, r;
        t_fraction res;
        an  = req.a_num;
        ad  = req.a_den;
        bn  = req.b_num;
        bd  = req.b_den;
        res = '0;
        case (req.op)
            rar_pkg::OP_ADD: begin
                num = an * bd + bn * ad;
                den = ad * bd;
            end
            rar_pkg::OP_SUB: begin
                num = an * bd - bn * ad;
                den = ad * bd;
            end
            rar_pkg::OP_MUL: begin
                num = an * bn;
                den = ad * bd;
            end
            default: begin
                num = an * bd;
                den = ad * bn;
            end
        endcase
        if (ad == 0 || bd == 0 || (req.op == rar_pkg::OP_DIV && bn == 0) || den == 0) begin
            res.err = 1'b1;
            return res;
        end
        // zero numerator goes out as computed
        if (num != 0) begin
            x = (num < 0) ? -num : num;
            y = (den < 0) ? -den : den;
            while (y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            // exact division, so truncation keeps the signs
            if (x > 1) begin
                num = num / x;
                den = den / x;
            end
        end
        res.num = num[rar_pkg::RES_NUM_W-1:0];
        res.den = den[rar_pkg::RES_DEN_W-1:0];
        return res;
    endfunction

    // operand mix: full range, small values, shared factors and extremes
    function automatic rar_pkg::t_operand random_operand();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom());
            4, 5:       v = int'($urandom_range(0, 40)) - 20;
            6:          v = (int'($urandom_range(1, 60)) - 30) * (1 << $urandom_range(0, 9));
            7: begin
                v = int'($urandom_range(1, 9)) * int'($urandom_range(1, 3000));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            8: begin
                case ($urandom_range(0, 5))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = -1;
                    3: v = 1;
                    4: v = 0;
                    default: v = -32767;
                endcase
            end
            default: v = int'($urandom_range(0, 255)) - 128;
        endcase
        return v[rar_pkg::OPERAND_WIDTH-1:0];
    endfunction

    function automatic t_request random_request();
        t_request req;
        req.op    = rar_pkg::OP_W'($urandom_range(0, 3));
        req.a_num = random_operand();
        req.a_den = random_operand();
        req.b_num = random_operand();
        req.b_den = random_operand();
        return req;
    endfunction

    // sender gap: mostly none or short, a few long
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // offer one request and wait for the handshake
    task automatic offer_request(t_request req, logic known, t_fraction known_res);
        t_fraction want;
        want = known ? known_res : reduce_fraction(req);
        s_axis_tdata  <= {req.b_den, req.b_num, req.a_den, req.a_num};
        s_axis_tuser  <= req.op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_fractions.push_back(want);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // an empty queue here means a pause has already dropped tvalid
    task automatic wait_results_drained();
        if (pending_fractions.size() != 0) begin
            s_axis_tvalid <= 1'b0;
            while (pending_fractions.size() != 0)
                @(posedge i_clk);
        end
    endtask

    // stimulus
    initial begin
        bit quiet_block;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_ROWS; i++) begin
            offer_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].known,
                          DIRECTED_ROWS[i].want);
            pause_sender(sender_gap());
        end

        // hold the sink off and keep offering so the unit backs up
        s_axis_tvalid     <= 1'b0;
        sink_hold_request  = 1'b1;
        while (!sink_holding)
            @(posedge i_clk);
        for (int i = 0; i < BACKLOG_REQUESTS; i++)
            offer_request(random_request(), 1'b0, '0);
        wait_results_drained();

        // random blocks, some with no sender gaps
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            quiet_block = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < BLOCK_REQUESTS; i++) begin
                offer_request(random_request(), 1'b0, '0);
                if (!quiet_block)
                    pause_sender(sender_gap());
            end
            if (b % 6 == 5)
                wait_results_drained();
        end

        // drain and finish
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("rational_arithmetic_reduce: match");
        end else begin
            $display("rational_arithmetic_reduce: mismatch");
        end
        $finish;
    end

    // sink: random ready pattern, plus one long hold-off on request
    initial begin
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (sink_hold_request) begin
                m_axis_tready <= 1'b0;
                sink_holding   = 1'b1;
                for (int c = 0; c < SINK_HOLD_CYCLES; c++)
                    @(posedge i_clk);
                sink_holding      = 1'b0;
                sink_hold_request = 1'b0;
            end
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 300)) @(posedge i_clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            m_axis_tready <= 1'b0;
            case ($urandom_range(0, 19))
                0:          repeat ($urandom_range(30, 120)) @(posedge i_clk);
                1, 2, 3:    repeat ($urandom_range(4, 15)) @(posedge i_clk);
                default:    repeat ($urandom_range(1, 3)) @(posedge i_clk);
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_fraction.num = m_axis_tdata[rar_pkg::RES_NUM_W-1:0];
            got_fraction.den =
                m_axis_tdata[rar_pkg::RES_NUM_W+rar_pkg::RES_DEN_W-1:rar_pkg::RES_NUM_W];
            got_fraction.err = m_axis_tuser;
            if (pending_fractions.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result num=%0d den=%0d err=%0b",
                             got_fraction.num, got_fraction.den, got_fraction.err);
            end else begin
                want_fraction = pending_fractions.pop_front();
                if (got_fraction.num !== want_fraction.num
                        || got_fraction.den !== want_fraction.den
                        || got_fraction.err !== want_fraction.err) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result differs: exp %0d/%0d err=%0b, got %0d/%0d err=%0b",
                                 want_fraction.num, want_fraction.den, want_fraction.err,
                                 got_fraction.num, got_fraction.den, got_fraction.err);
                end
            end
        end
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("rational_arithmetic_reduce: mismatch");
        $finish;
    end

endmodule
